// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LEWR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// expression must never be true outside reset
`define LEWR_NEVER(lbl, clk, rst, expr, msg) \
   `LEWR_ASSERT(lbl, clk, rst, !(expr), msg)

`endif

// ===== rtl/lewr_pkg.sv =====
// ----------------------------------------------------------------------------
// Line editor word wrap package
// Sizes, key codes, command codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lewr_pkg;

   localparam int LINE_MAX = 40;
   localparam int LEN_W    = $clog2(LINE_MAX + 1);
   localparam int ADDR_W   = $clog2(LINE_MAX);
   localparam int ERASE_W  = 6;

   localparam logic [7:0] KEY_WORD_ERASE = 8'h17;
   localparam logic [7:0] KEY_END        = 8'h04;
   localparam logic [7:0] KEY_SPACE      = 8'h20;
   localparam logic [7:0] PRINT_LO       = 8'h21;
   localparam logic [7:0] PRINT_HI       = 8'h7E;

   localparam logic [7:0] ERASE_RESET = 8'd127;
   localparam logic [7:0] KILL_RESET  = 8'd21;

   typedef enum logic [2:0] {
      CMD_PRINT   = 3'd0,
      CMD_ERASE   = 3'd1,
      CMD_NEWLINE = 3'd2,
      CMD_BELL    = 3'd3,
      CMD_END     = 3'd4
   } cmd_type;

   typedef enum logic {
      CSR_ERASE_CHAR = 1'b0,
      CSR_KILL_CHAR  = 1'b1
   } csr_idx_type;

endpackage

`default_nettype wire

// ===== rtl/lewr_if.sv =====
// ----------------------------------------------------------------------------
// Line editor word wrap channels
// Valid/ready channels for typed bytes, display commands and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lewr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] typed_byte;

   modport source (output valid, output typed_byte, input ready);
   modport sink   (input valid, input typed_byte, output ready);
endinterface

interface lewr_rsp_if
   import lewr_pkg::*;
   ;
   logic               valid;
   logic               ready;
   cmd_type            command;
   logic [7:0]         out_byte;
   logic [ERASE_W-1:0] erase_count;
   logic               last;

   modport source (output valid, output command, output out_byte,
                   output erase_count, output last, input ready);
   modport sink   (input valid, input command, input out_byte,
                   input erase_count, input last, output ready);
endinterface

interface lewr_csr_if
   import lewr_pkg::*;
   ;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   logic [7:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/lewr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lewr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 40
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/line_editor_word_wrap_unit.sv =====
// ----------------------------------------------------------------------------
// Line editor word wrap unit
// Keeps a line buffer and turns typed bytes into display commands.
// ----------------------------------------------------------------------------
//
//   port     dir   handshake      payload
//   req_bus  in    valid/ready    typed_byte
//   rsp_bus  out   valid/ready    command, out_byte, erase_count, last
//   csr_bus  in    valid/ready    index, wdata (always ready)
//
// One byte at a time; req ready only while the sequencer is idle.
// Erase, kill, end and bell keys are answered from the decode state; a space or
// printable byte adds an append state; word erase scans the buffer entry by entry.
// Wrap scans the buffer, then retypes each moved char, reading it and then
// writing it back. Result stalls hold the sequencer.
// Synchronous reset clears length, registers and control; buffer is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module line_editor_word_wrap_unit
   import lewr_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   lewr_req_if.sink   req_bus,
   lewr_rsp_if.source rsp_bus,
   lewr_csr_if.sink   csr_bus
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CHK, S_SCAN_DONE,
      S_NEWLINE, S_COPY_RD, S_COPY_WR, S_APPEND
   } state_type;

   typedef enum logic [2:0] {
      K_ERASE, K_KILL, K_WERASE, K_END, K_SPACE, K_PRINT, K_BELL
   } key_type;

   state_type          state_ff,   state_in;
   key_type            key_ff,     key_in;
   logic [7:0]         byte_ff,    byte_in;
   logic [LEN_W-1:0]   len_ff,     len_in;
   logic [LEN_W-1:0]   idx_ff,     idx_in;
   logic [LEN_W-1:0]   cnt_ff,     cnt_in;
   logic               phase_ff,   phase_in;
   logic               first_ff,   first_in;
   logic               trail_ff,   trail_in;
   logic [7:0]         erase_ff,   erase_in;
   logic [7:0]         kill_ff,    kill_in;
   logic               valid_ff,   valid_in;
   cmd_type            cmd_ff,     cmd_in;
   logic [7:0]         obyte_ff,   obyte_in;
   logic [ERASE_W-1:0] ecnt_ff,    ecnt_in;
   logic               last_ff,    last_in;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [7:0]         ram_wdata;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [7:0]         ram_rdata;

   logic               out_free;
   logic               emit;
   cmd_type            e_cmd;
   logic [7:0]         e_byte;
   logic [LEN_W-1:0]   e_cnt;
   logic               e_last;
   logic [LEN_W-1:0]   idx_dec;
   logic [LEN_W-1:0]   word_len;
   logic               line_full;
   logic               req_take;
   logic               csr_take;

   lewr_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.command     = cmd_ff;
   assign rsp_bus.out_byte    = obyte_ff;
   assign rsp_bus.erase_count = ecnt_ff;
   assign rsp_bus.last        = last_ff;

   assign req_take  = req_bus.valid && req_bus.ready;
   assign csr_take  = csr_bus.valid;
   assign out_free  = !valid_ff || rsp_bus.ready;
   assign idx_dec   = idx_ff - LEN_W'(1);
   assign word_len  = len_ff - idx_ff;
   assign line_full = (len_ff >= LEN_W'(LINE_MAX));

   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      byte_in   = byte_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      phase_in  = phase_ff;
      first_in  = first_ff;
      trail_in  = trail_ff;
      erase_in  = erase_ff;
      kill_in   = kill_ff;
      ram_we    = 1'b0;
      ram_waddr = len_ff[ADDR_W-1:0];
      ram_wdata = byte_ff;
      ram_re    = 1'b0;
      ram_raddr = idx_ff[ADDR_W-1:0];
      emit      = 1'b0;
      e_cmd     = CMD_PRINT;
      e_byte    = 8'd0;
      e_cnt     = '0;
      e_last    = 1'b0;

      if (csr_take) begin
         case (csr_bus.index)
            CSR_ERASE_CHAR: erase_in = csr_bus.wdata;
            CSR_KILL_CHAR:  kill_in  = csr_bus.wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               byte_in  = req_bus.typed_byte;
               state_in = S_DECODE;
               if (req_bus.typed_byte == erase_ff) begin
                  key_in = K_ERASE;
               end else if (req_bus.typed_byte == kill_ff) begin
                  key_in = K_KILL;
               end else if (req_bus.typed_byte == KEY_WORD_ERASE) begin
                  key_in = K_WERASE;
               end else if (req_bus.typed_byte == KEY_END) begin
                  key_in = K_END;
               end else if (req_bus.typed_byte == KEY_SPACE) begin
                  key_in = K_SPACE;
               end else if (req_bus.typed_byte >= PRINT_LO &&
                            req_bus.typed_byte <= PRINT_HI) begin
                  key_in = K_PRINT;
               end else begin
                  key_in = K_BELL;
               end
            end
         end

         S_DECODE: begin
            if (out_free) begin
               state_in = S_IDLE;
               case (key_ff)
                  K_ERASE: begin
                     if (len_ff != '0) begin
                        emit   = 1'b1;
                        e_cmd  = CMD_ERASE;
                        e_cnt  = LEN_W'(1);
                        e_last = 1'b1;
                        len_in = len_ff - LEN_W'(1);
                     end
                  end
                  K_KILL: begin
                     if (len_ff != '0) begin
                        emit   = 1'b1;
                        e_cmd  = CMD_ERASE;
                        e_cnt  = len_ff;
                        e_last = 1'b1;
                        len_in = '0;
                     end
                  end
                  K_END: begin
                     if (len_ff == '0) begin
                        emit   = 1'b1;
                        e_cmd  = CMD_END;
                        e_last = 1'b1;
                     end
                  end
                  K_SPACE: begin
                     if (line_full) begin
                        emit   = 1'b1;
                        e_cmd  = CMD_NEWLINE;
                        e_last = 1'b1;
                        len_in = '0;
                     end else begin
                        state_in = S_APPEND;
                     end
                  end
                  K_WERASE, K_PRINT: begin
                     if (key_ff == K_PRINT && !line_full) begin
                        state_in = S_APPEND;
                     end else begin
                        idx_in   = len_ff;
                        phase_in = 1'b0;
                        first_in = 1'b1;
                        trail_in = 1'b0;
                        state_in = S_SCAN_RD;
                     end
                  end
                  default: begin
                     emit   = 1'b1;
                     e_cmd  = CMD_BELL;
                     e_last = 1'b1;
                  end
               endcase
            end
         end

         S_SCAN_RD: begin
            if (idx_ff == '0) begin
               state_in = S_SCAN_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = idx_dec[ADDR_W-1:0];
               state_in  = S_SCAN_CHK;
            end
         end

         S_SCAN_CHK: begin
            first_in = 1'b0;
            if (ram_rdata == KEY_SPACE) begin
               if (!phase_ff) begin
                  if (first_ff) begin
                     trail_in = 1'b1;
                  end
                  idx_in   = idx_dec;
                  state_in = S_SCAN_RD;
               end else begin
                  state_in = S_SCAN_DONE;
               end
            end else begin
               phase_in = 1'b1;
               idx_in   = idx_dec;
               state_in = S_SCAN_RD;
            end
         end

         S_SCAN_DONE: begin
            if (out_free) begin
               if (key_ff == K_WERASE) begin
                  state_in = S_IDLE;
                  if (word_len != '0) begin
                     emit   = 1'b1;
                     e_cmd  = CMD_ERASE;
                     e_cnt  = word_len;
                     e_last = 1'b1;
                     len_in = idx_ff;
                  end
               end else if (idx_ff == '0 || trail_ff) begin
                  // nothing to move: plain newline
                  emit     = 1'b1;
                  e_cmd    = CMD_NEWLINE;
                  len_in   = '0;
                  state_in = S_APPEND;
               end else begin
                  emit     = 1'b1;
                  e_cmd    = CMD_ERASE;
                  e_cnt    = word_len;
                  cnt_in   = word_len;
                  len_in   = idx_ff;
                  state_in = S_NEWLINE;
               end
            end
         end

         S_NEWLINE: begin
            if (out_free) begin
               emit     = 1'b1;
               e_cmd    = CMD_NEWLINE;
               len_in   = '0;
               state_in = S_COPY_RD;
            end
         end

         S_COPY_RD: begin
            if (cnt_ff == '0) begin
               state_in = S_APPEND;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = idx_ff[ADDR_W-1:0];
               state_in  = S_COPY_WR;
            end
         end

         S_COPY_WR: begin
            if (out_free) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
               emit      = 1'b1;
               e_cmd     = CMD_PRINT;
               e_byte    = ram_rdata;
               len_in    = len_ff + LEN_W'(1);
               idx_in    = idx_ff + LEN_W'(1);
               cnt_in    = cnt_ff - LEN_W'(1);
               state_in  = S_COPY_RD;
            end
         end

         S_APPEND: begin
            if (out_free) begin
               ram_we    = 1'b1;
               ram_wdata = byte_ff;
               emit      = 1'b1;
               e_cmd     = CMD_PRINT;
               e_byte    = byte_ff;
               e_last    = 1'b1;
               len_in    = len_ff + LEN_W'(1);
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      obyte_in = obyte_ff;
      ecnt_in  = ecnt_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         cmd_in   = e_cmd;
         obyte_in = e_byte;
         ecnt_in  = ERASE_W'(e_cnt);
         last_in  = e_last;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
         erase_ff <= ERASE_RESET;
         kill_ff  <= KILL_RESET;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         erase_ff <= erase_in;
         kill_ff  <= kill_in;
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      byte_ff  <= byte_in;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
      first_ff <= first_in;
      trail_ff <= trail_in;
      cmd_ff   <= cmd_in;
      obyte_ff <= obyte_in;
      ecnt_ff  <= ecnt_in;
      last_ff  <= last_in;
   end

   `LEWR_NEVER(a_len_bound, clock, reset, len_ff > LEN_W'(LINE_MAX), "line length overflow")
   `LEWR_NEVER(a_ram_port, clock, reset, ram_we && ram_re, "buffer read and write together")
   `LEWR_ASSERT(a_one_item, clock, reset, req_take |=> !req_bus.ready, "second byte taken")
   `LEWR_ASSERT(a_no_overrun, clock, reset, emit |-> out_free, "result register overrun")

endmodule

`default_nettype wire
